// ===== rtl/core/drsp_pkg.sv =====
// ----------------------------------------------------------------------------
// drsp_pkg
// Types and constants shared by the decimal record stream parser files.
// ----------------------------------------------------------------------------
package drsp_pkg;

	localparam int unsigned NAME_LEN = 16;

	localparam logic [7:0] NEWLINE    = 8'd10;
	localparam logic [7:0] DIGIT_ZERO = 8'd48;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned POS_W   = 5;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_SLOT = 2'd1,
		PH_TRAY = 2'd2,
		PH_REC  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		RF_NAME   = 2'd0,
		RF_NUMBER = 2'd1,
		RF_AMOUNT = 2'd2,
		RF_PRICE  = 2'd3
	} rec_field_t;

	localparam logic [2:0] KIND_SLOT   = 3'd0;
	localparam logic [2:0] KIND_TRAY   = 3'd1;
	localparam logic [2:0] KIND_NAME   = 3'd2;
	localparam logic [2:0] KIND_NUMBER = 3'd3;
	localparam logic [2:0] KIND_AMOUNT = 3'd4;
	localparam logic [2:0] KIND_PRICE  = 3'd5;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_message;
		logic       end_of_message;
	} in_word_t;

	typedef struct packed {
		logic [2:0]         field_kind;
		logic [7:0]         record_index;
		logic [3:0]         char_position;
		logic [VALUE_W-1:0] field_value;
	} out_word_t;

endpackage

// ===== rtl/core/drsp_in_if.sv =====
// ----------------------------------------------------------------------------
// drsp_in_if
// Valid/ready channel carrying one message byte with its framing marks.
// ----------------------------------------------------------------------------
interface drsp_in_if;
	logic              valid;
	logic              ready;
	drsp_pkg::in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/drsp_out_if.sv =====
// ----------------------------------------------------------------------------
// drsp_out_if
// Valid/ready channel carrying one table write event.
// ----------------------------------------------------------------------------
interface drsp_out_if;
	logic               valid;
	logic               ready;
	drsp_pkg::out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/decimal_record_stream_parser_top.sv =====
// ----------------------------------------------------------------------------
// decimal_record_stream_parser_top
// Parses an upload message into slot/tray header values and record writes.
// ----------------------------------------------------------------------------
// Takes one byte word per cycle on rx unless tx stalls, and gives at most one
// write event per byte on tx. A byte is captured in an input register,
// then parsed against the parser state into the result register. The
// sustained rate of one byte per cycle without stalls is set by the single
// multiply-by-ten-and-add of the accumulator. The first byte of a message
// (start_of_message) is skipped, and the parser idles after end_of_message.
// Name characters past NAME_LEN are dropped without a word on tx.
module decimal_record_stream_parser_top (
	input  logic       clk,
	input  logic       arst_n,
	drsp_in_if.sink    rx,
	drsp_out_if.source tx
);

	// input register
	logic               v_s1;
	drsp_pkg::in_word_t in_s1;
	logic               adv;

	// parser state
	drsp_pkg::phase_t                 phase_q, phase_d;
	drsp_pkg::rec_field_t             field_q, field_d;
	logic [drsp_pkg::VALUE_W-1:0]     acc_q, acc_d;
	logic [drsp_pkg::POS_W-1:0]       pos_q, pos_d;
	logic [7:0]                       entry_q, entry_d;

	// result register
	logic                 out_v_q;
	drsp_pkg::out_word_t  out_q;
	logic                 res_v;
	drsp_pkg::out_word_t  res;

	logic                 is_nl;
	logic [drsp_pkg::VALUE_W-1:0] acc_next;
	logic                 name_room;

	assign adv      = v_s1 && (!out_v_q || tx.ready);
	assign rx.ready = !v_s1 || adv;

	assign is_nl     = (in_s1.data_byte == drsp_pkg::NEWLINE);
	// acc * 10 + byte - '0', modulo 2^32
	assign acc_next  = (acc_q << 3) + (acc_q << 1)
		+ {{(drsp_pkg::VALUE_W-8){1'b0}}, in_s1.data_byte}
		- {{(drsp_pkg::VALUE_W-8){1'b0}}, drsp_pkg::DIGIT_ZERO};
	assign name_room = ({1'b0, pos_q} < (drsp_pkg::POS_W+1)'(drsp_pkg::NAME_LEN));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rx.ready) begin
			v_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			in_s1 <= rx.data;
		end
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		field_d = field_q;
		acc_d   = acc_q;
		pos_d   = pos_q;
		entry_d = entry_q;
		if (in_s1.start_of_message) begin
			phase_d = in_s1.end_of_message ? drsp_pkg::PH_IDLE : drsp_pkg::PH_SLOT;
			field_d = drsp_pkg::RF_NAME;
			acc_d   = '0;
			pos_d   = '0;
			entry_d = 8'd1;
		end else begin
			unique case (phase_q) inside
				drsp_pkg::PH_IDLE: ;
				drsp_pkg::PH_SLOT, drsp_pkg::PH_TRAY: begin
					if (is_nl) begin
						acc_d   = '0;
						phase_d = (phase_q == drsp_pkg::PH_SLOT) ? drsp_pkg::PH_TRAY
							: drsp_pkg::PH_REC;
					end else begin
						acc_d = acc_next;
					end
				end
				drsp_pkg::PH_REC: begin
					if (field_q == drsp_pkg::RF_NAME) begin
						if (is_nl) begin
							field_d = drsp_pkg::RF_NUMBER;
							pos_d   = '0;
						end else if (name_room) begin
							pos_d = pos_q + 1'b1;
						end
					end else if (is_nl) begin
						acc_d = '0;
						if (field_q == drsp_pkg::RF_PRICE) begin
							field_d = drsp_pkg::RF_NAME;
							entry_d = entry_q + 8'd1;
						end else begin
							field_d = drsp_pkg::rec_field_t'(field_q + 2'd1);
						end
					end else begin
						acc_d = acc_next;
					end
				end
				default: ;
			endcase
			if (in_s1.end_of_message) begin
				phase_d = drsp_pkg::PH_IDLE;
			end
		end
	end

	// result word
	always_comb begin
		res_v = 1'b0;
		res   = '0;
		if (!in_s1.start_of_message) begin
			unique case (phase_q) inside
				drsp_pkg::PH_IDLE: ;
				drsp_pkg::PH_SLOT, drsp_pkg::PH_TRAY: begin
					res_v = is_nl;
					res.field_kind  = (phase_q == drsp_pkg::PH_SLOT) ? drsp_pkg::KIND_SLOT
						: drsp_pkg::KIND_TRAY;
					res.field_value = acc_q;
				end
				drsp_pkg::PH_REC: begin
					res.record_index = entry_q;
					if (field_q == drsp_pkg::RF_NAME) begin
						res_v             = !is_nl && name_room;
						res.field_kind    = drsp_pkg::KIND_NAME;
						res.char_position = pos_q[3:0];
						res.field_value   = {{(drsp_pkg::VALUE_W-8){1'b0}}, in_s1.data_byte};
					end else begin
						res_v           = is_nl;
						res.field_kind  = drsp_pkg::KIND_NAME + {1'b0, field_q};
						res.field_value = acc_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= drsp_pkg::PH_IDLE;
			field_q <= drsp_pkg::RF_NAME;
			acc_q   <= '0;
			pos_q   <= '0;
			entry_q <= 8'd1;
			out_v_q <= 1'b0;
		end else begin
			if (adv) begin
				phase_q <= phase_d;
				field_q <= field_d;
				acc_q   <= acc_d;
				pos_q   <= pos_d;
				entry_q <= entry_d;
				out_v_q <= res_v;
			end else if (tx.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_v) begin
			out_q <= res;
		end
	end

	assign tx.valid = out_v_q;
	assign tx.data  = out_q;

endmodule

// ===== rtl/core/drsp_chk.sv =====
// ----------------------------------------------------------------------------
// drsp_chk
// Port-level checks on the write events of the record stream parser.
// ----------------------------------------------------------------------------
module drsp_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       tx_valid,
	input logic       tx_ready,
	input logic [2:0] field_kind,
	input logic [7:0] record_index,
	input logic [3:0] char_position
);

	// a stalled word stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && !tx_ready |=> tx_valid)
		else $error("drsp: tx word dropped while stalled");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid |-> field_kind <= drsp_pkg::KIND_PRICE)
		else $error("drsp: field kind out of range");

	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && field_kind != drsp_pkg::KIND_NAME |-> char_position == 4'd0)
		else $error("drsp: char position set on a decimal field");

	// header values never carry an entry
	a_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		tx_valid && (field_kind == drsp_pkg::KIND_SLOT || field_kind == drsp_pkg::KIND_TRAY)
		|-> record_index == 8'd0)
		else $error("drsp: header word with record index");

endmodule

bind decimal_record_stream_parser_top drsp_chk u_drsp_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.tx_valid      (tx.valid),
	.tx_ready      (tx.ready),
	.field_kind    (tx.data.field_kind),
	.record_index  (tx.data.record_index),
	.char_position (tx.data.char_position)
);

// ===== verif/tb_decimal_record_stream_parser_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_decimal_record_stream_parser_top
// Self-checking bench for the upload message parser.
// ----------------------------------------------------------------------------
// Drives byte words on rx and compares every table write event on tx against
// a cycle-free model of the parser state kept in a small tracker class.
// A directed warm-up covers idle bytes, combined start/end marks, restarts,
// non-digit bytes and truncated fields. Random messages follow, mostly well
// formed with truncations and restarts mixed in, and one long message of
// short records closes the run. Both sides idle at random and the receiver
// holds off for a long stretch so that the input stalls.
// ----------------------------------------------------------------------------
module tb_decimal_record_stream_parser_top;

	class parse_tracker;
		drsp_pkg::out_word_t  pending_writes[$];
		int                   mismatches;
		drsp_pkg::phase_t     phase;
		drsp_pkg::rec_field_t field;
		logic [31:0]          acc;
		logic [4:0]           name_pos;
		logic [7:0]           entry;

		function new();
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			phase    = drsp_pkg::PH_IDLE;
			field    = drsp_pkg::RF_NAME;
			acc      = '0;
			name_pos = '0;
			entry    = 8'd1;
		endfunction

		function string fmt_word(drsp_pkg::out_word_t w);
			return $sformatf("kind %0d rec %0d pos %0d value %h",
				w.field_kind, w.record_index, w.char_position, w.field_value);
		endfunction

		// Advances the parser state by one accepted byte word and queues the
		// write event it produces, if any.
		function void note_byte(drsp_pkg::in_word_t w);
			drsp_pkg::out_word_t ev;
			bit                  hit;
			hit = 1'b0;
			ev  = '0;
			if (w.start_of_message) begin
				restart();
				phase = w.end_of_message ? drsp_pkg::PH_IDLE : drsp_pkg::PH_SLOT;
				return;
			end
			if (phase == drsp_pkg::PH_IDLE)
				return;
			if (phase != drsp_pkg::PH_REC) begin
				if (w.data_byte == drsp_pkg::NEWLINE) begin
					ev.field_kind  = (phase == drsp_pkg::PH_SLOT) ? drsp_pkg::KIND_SLOT
						: drsp_pkg::KIND_TRAY;
					ev.field_value = acc;
					hit   = 1'b1;
					acc   = '0;
					phase = (phase == drsp_pkg::PH_SLOT) ? drsp_pkg::PH_TRAY
						: drsp_pkg::PH_REC;
				end else begin
					acc = acc * 32'd10 + {24'd0, w.data_byte}
						- {24'd0, drsp_pkg::DIGIT_ZERO};
				end
			end else if (field == drsp_pkg::RF_NAME) begin
				if (w.data_byte == drsp_pkg::NEWLINE) begin
					field    = drsp_pkg::RF_NUMBER;
					name_pos = '0;
				end else if (name_pos < drsp_pkg::NAME_LEN) begin
					ev.field_kind    = drsp_pkg::KIND_NAME;
					ev.record_index  = entry;
					ev.char_position = name_pos[3:0];
					ev.field_value   = {24'd0, w.data_byte};
					hit      = 1'b1;
					name_pos = name_pos + 5'd1;
				end
			end else begin
				if (w.data_byte == drsp_pkg::NEWLINE) begin
					case (field)
						drsp_pkg::RF_NUMBER: ev.field_kind = drsp_pkg::KIND_NUMBER;
						drsp_pkg::RF_AMOUNT: ev.field_kind = drsp_pkg::KIND_AMOUNT;
						default:             ev.field_kind = drsp_pkg::KIND_PRICE;
					endcase
					ev.record_index = entry;
					ev.field_value  = acc;
					hit = 1'b1;
					acc = '0;
					if (field == drsp_pkg::RF_PRICE) begin
						field = drsp_pkg::RF_NAME;
						entry = entry + 8'd1;
					end else begin
						field = drsp_pkg::rec_field_t'(field + 2'd1);
					end
				end else begin
					acc = acc * 32'd10 + {24'd0, w.data_byte}
						- {24'd0, drsp_pkg::DIGIT_ZERO};
				end
			end
			if (hit)
				pending_writes.push_back(ev);
			if (w.end_of_message)
				phase = drsp_pkg::PH_IDLE;
		endfunction

		function void check_event(drsp_pkg::out_word_t got);
			drsp_pkg::out_word_t want;
			if (pending_writes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected write: expected none, got %s", fmt_word(got));
				return;
			end
			want = pending_writes.pop_front();
			if (got.field_kind !== want.field_kind || got.record_index !== want.record_index ||
					got.char_position !== want.char_position ||
					got.field_value !== want.field_value) begin
				mismatches++;
				if (mismatches <= 10)
					$display("write mismatch: expected %s, got %s",
						fmt_word(want), fmt_word(got));
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	drsp_in_if  rx_if ();
	drsp_out_if tx_if ();

	parse_tracker tracker = new();

	bit                 steady_run;
	bit                 stall_request;
	int unsigned        words_sent;
	drsp_pkg::in_word_t message_words[$];

	decimal_record_stream_parser_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.tx     (tx_if)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic drsp_pkg::in_word_t make_word(logic [7:0] b, logic som, logic eom);
		drsp_pkg::in_word_t w;
		w.data_byte        = b;
		w.start_of_message = som;
		w.end_of_message   = eom;
		return w;
	endfunction

	function automatic logic [7:0] any_but_newline();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == drsp_pkg::NEWLINE);
		return b;
	endfunction

	function automatic void add_decimal();
		int n;
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 13) : $urandom_range(0, 4);
		repeat (n) begin
			if ($urandom_range(0, 11) == 0)
				message_words.push_back(make_word(any_but_newline(), 1'b0, 1'b0));
			else
				message_words.push_back(make_word(8'(8'h30 + $urandom_range(0, 9)),
					1'b0, 1'b0));
		end
		message_words.push_back(make_word(drsp_pkg::NEWLINE, 1'b0, 1'b0));
	endfunction

	function automatic void add_name();
		int n;
		n = ($urandom_range(0, 4) == 0)
			? $urandom_range(drsp_pkg::NAME_LEN - 1, drsp_pkg::NAME_LEN + 4)
			: $urandom_range(0, 6);
		repeat (n)
			message_words.push_back(make_word(any_but_newline(), 1'b0, 1'b0));
		message_words.push_back(make_word(drsp_pkg::NEWLINE, 1'b0, 1'b0));
	endfunction

	task automatic send_word(input drsp_pkg::in_word_t w);
		while (!steady_run && $urandom_range(0, 99) < 28) begin
			rx_if.valid <= 1'b0;
			@(posedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.data  <= w;
		@(posedge clk);
		while (!rx_if.ready)
			@(posedge clk);
		tracker.note_byte(w);
		words_sent++;
	endtask

	task automatic send_random_message();
		int n_rec;
		int cut;
		int restart_at;
		int i;
		message_words.delete();
		message_words.push_back(make_word(8'($urandom_range(0, 255)), 1'b1, 1'b0));
		add_decimal();
		add_decimal();
		n_rec = $urandom_range(1, 4);
		repeat (n_rec) begin
			add_name();
			repeat (3)
				add_decimal();
		end
		restart_at = -1;
		case ($urandom_range(0, 19))
			0, 1: begin
				// end mark lands mid-message, often inside an open field
				cut = $urandom_range(1, message_words.size() - 1);
				while (message_words.size() > cut + 1)
					void'(message_words.pop_back());
			end
			2: restart_at = $urandom_range(1, message_words.size() - 1);
			default: ;
		endcase
		message_words[message_words.size() - 1].end_of_message = 1'b1;
		for (i = 0; i < message_words.size(); i++) begin
			if (i == restart_at)
				send_word(make_word(8'($urandom_range(0, 255)), 1'b1, 1'b0));
			send_word(message_words[i]);
		end
		// stray bytes between messages are ignored by the parser
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 2))
				send_word(make_word(8'($urandom_range(0, 255)), 1'b0,
					1'($urandom_range(0, 1))));
	endtask

	// A long message of short records, sent while the receiver holds off.
	task automatic send_long_message();
		message_words.delete();
		message_words.push_back(make_word(8'($urandom_range(0, 255)), 1'b1, 1'b0));
		message_words.push_back(make_word(drsp_pkg::NEWLINE, 1'b0, 1'b0));
		message_words.push_back(make_word(drsp_pkg::NEWLINE, 1'b0, 1'b0));
		repeat (24) begin
			message_words.push_back(make_word(any_but_newline(), 1'b0, 1'b0));
			repeat (4)
				message_words.push_back(make_word(drsp_pkg::NEWLINE, 1'b0, 1'b0));
		end
		message_words[message_words.size() - 1].end_of_message = 1'b1;
		stall_request = 1'b1;
		foreach (message_words[i])
			send_word(message_words[i]);
	endtask

	initial begin : receiver
		int hold_left;
		hold_left = 0;
		tx_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (tx_if.valid && tx_if.ready)
				tracker.check_event(tx_if.data);
			if (stall_request) begin
				stall_request = 1'b0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				tx_if.ready <= 1'b0;
				hold_left--;
			end else begin
				tx_if.ready <= steady_run || ($urandom_range(0, 99) >= 28);
			end
		end
	end

	initial begin : stimulus
		bit stalled_once;
		stalled_once  = 1'b0;
		steady_run    = 1'b0;
		stall_request = 1'b0;
		words_sent    = 0;
		arst_n      <= 1'b0;
		rx_if.valid <= 1'b0;
		rx_if.data  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(make_word(8'h00, 1'b0, 1'b0));   // idle, ignored
		send_word(make_word(8'hff, 1'b1, 1'b1));   // start and end together
		send_word(make_word(drsp_pkg::NEWLINE, 1'b0, 1'b0));
		send_word(make_word(8'ha5, 1'b1, 1'b0));
		send_word(make_word(8'hff, 1'b0, 1'b0));   // non-digit in slot count
		send_word(make_word(drsp_pkg::NEWLINE, 1'b0, 1'b0));
		send_word(make_word(drsp_pkg::NEWLINE, 1'b0, 1'b0)); // empty tray count
		send_word(make_word(8'h41, 1'b0, 1'b0));
		send_word(make_word(8'h80, 1'b0, 1'b0));
		send_word(make_word(drsp_pkg::NEWLINE, 1'b0, 1'b0)); // name terminator
		send_word(make_word(8'h37, 1'b0, 1'b0));
		send_word(make_word(drsp_pkg::NEWLINE, 1'b0, 1'b0));
		send_word(make_word(drsp_pkg::NEWLINE, 1'b0, 1'b0));
		send_word(make_word(8'h00, 1'b0, 1'b0));   // price wraps below zero
		send_word(make_word(drsp_pkg::NEWLINE, 1'b0, 1'b0));
		send_word(make_word(8'h33, 1'b0, 1'b0));   // second record
		send_word(make_word(8'h5a, 1'b1, 1'b0));   // restart mid-message
		send_word(make_word(8'h31, 1'b0, 1'b0));
		send_word(make_word(drsp_pkg::NEWLINE, 1'b0, 1'b0));
		send_word(make_word(8'h32, 1'b0, 1'b1));   // tray left open
		send_word(make_word(8'h35, 1'b0, 1'b0));   // idle again

		while (words_sent < 400) begin
			steady_run = (words_sent >= 220 && words_sent < 340);
			if (!stalled_once && words_sent >= 120) begin
				stall_request = 1'b1;
				stalled_once  = 1'b1;
			end
			send_random_message();
		end
		steady_run = 1'b0;
		send_long_message();
		rx_if.valid <= 1'b0;

		while (tracker.pending_writes.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("tb_decimal_record_stream_parser_top passed");
		else
			$display("tb_decimal_record_stream_parser_top failed");
		$finish;
	end

	initial begin : watchdog
		#400000;
		$display("tb_decimal_record_stream_parser_top failed");
		$finish;
	end

endmodule
